// ----- rtl/core/lzwvd_pkg.sv -----
package lzwvd_pkg;

  localparam int MIN_CODE_BITS = 9;
  localparam int CHUNK_BYTES   = 64;
  localparam int MAX_CHUNKS    = 64;
  localparam int STRING_LIMIT  = CHUNK_BYTES * MAX_CHUNKS;
  localparam int BASE_W        = $clog2(STRING_LIMIT + 1);
  localparam int COUNT_W       = $clog2(CHUNK_BYTES + 1);
  localparam int SLOT_W        = $clog2(CHUNK_BYTES);
  localparam int CHUNK_W       = CHUNK_BYTES * 8;

  // decoder phase
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;
  localparam logic [1:0] PH_BAD   = 2'd3;

  // result status
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // code class
  localparam logic [1:0] CLS_HALT  = 2'd0;
  localparam logic [1:0] CLS_RESET = 2'd1;
  localparam logic [1:0] CLS_FIRST = 2'd2;
  localparam logic [1:0] CLS_WALK  = 2'd3;

  typedef struct packed {
    logic accept;
    logic classify;
    logic walk;
    logic root;
    logic chunk_start;
    logic emit;
    logic out_next;
  } dp_cmd_t;

  typedef struct packed {
    logic       have_code;
    logic [1:0] cls;
    logic       chain_big;
    logic       walk_more;
    logic       emit_done;
    logic       last;
  } dp_stat_t;

endpackage

// ----- rtl/core/lzwvd_ctrl.sv -----
module lzwvd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lzwvd_pkg::dp_stat_t stat,
  output lzwvd_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLASS  = 3'd1;
  localparam logic [2:0] S_WSTART = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_ROOT   = 3'd4;
  localparam logic [2:0] S_CHUNK  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd             = '0;
    cmd.accept      = (state_r == S_IDLE) && in_valid;
    cmd.classify    = (state_r == S_CLASS);
    cmd.walk        = (state_r == S_WALK);
    cmd.root        = (state_r == S_ROOT);
    cmd.chunk_start = (state_r == S_CHUNK);
    cmd.emit        = (state_r == S_EMIT);
    cmd.out_next    = (state_r == S_OUT) && !out_stall && !stat.last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid && stat.have_code) state_nxt = S_CLASS;
      S_CLASS: begin
        unique case (stat.cls)
          lzwvd_pkg::CLS_HALT:  state_nxt = S_OUT;
          lzwvd_pkg::CLS_RESET: state_nxt = S_IDLE;
          lzwvd_pkg::CLS_FIRST: state_nxt = S_CHUNK;
          default:              state_nxt = S_WSTART;
        endcase
      end
      S_WSTART: state_nxt = stat.chain_big ? S_WALK : S_ROOT;
      S_WALK:   state_nxt = stat.walk_more ? S_WALK : S_ROOT;
      S_ROOT:   state_nxt = S_CHUNK;
      S_CHUNK:  state_nxt = S_EMIT;
      S_EMIT:   if (stat.emit_done) state_nxt = S_OUT;
      S_OUT:    if (!out_stall) state_nxt = stat.last ? S_IDLE : S_CHUNK;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/lzwvd_dp.sv -----
module lzwvd_dp #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lzwvd_pkg::dp_cmd_t                 cmd,
  output lzwvd_pkg::dp_stat_t                stat,
  input  logic                               in_command,
  input  logic [7:0]                         in_data_byte,
  output logic [lzwvd_pkg::CHUNK_W-1:0]      chunk,
  output logic [lzwvd_pkg::COUNT_W-1:0]      byte_count,
  output logic                               last_chunk,
  output logic [1:0]                         status
);

  localparam int MB     = MAX_CODE_BITS;
  localparam int DICT   = 1 << MB;
  localparam int NW     = MB + 1;
  localparam int HW     = MB + 8;
  localparam int HB     = $clog2(MB + 9);
  localparam int WB     = $clog2(MB + 1);
  localparam int LW     = MB + 3;
  localparam int CW     = lzwvd_pkg::COUNT_W;
  localparam int BW     = lzwvd_pkg::BASE_W;
  localparam logic [MB-1:0] RESET_CODE = MB'(DICT - 1);
  localparam logic [MB-1:0] END_CODE   = MB'(DICT - 2);

  logic [MB-1:0] prefix_mem [DICT];
  logic [7:0]    suffix_mem [DICT];
  logic [7:0]    stack_mem  [DICT];

  logic [NW-1:0] nfc_r;
  logic [HW-1:0] holder_r;
  logic [HB-1:0] held_r;
  logic [MB-1:0] prev_r, code_r, chain_r;
  logic [7:0]    pf_r;
  logic [1:0]    phase_r;
  logic          kw_r;
  logic [LW-1:0] len_r;
  logic [NW-1:0] guard_r;
  logic [BW-1:0] base_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic          pend_r;
  logic [lzwvd_pkg::SLOT_W-1:0] slot_r;
  logic [lzwvd_pkg::CHUNK_W-1:0] chunk_r;
  logic          last_r;
  logic [1:0]    status_r;
  logic [MB-1:0] prefix_q;
  logic [7:0]    suffix_q, stack_q;

  // bit unpacking
  logic [WB-1:0] width;
  logic [HW-1:0] holder_sh, code_full;
  logic [HB-1:0] held_add, held_left;
  logic [MB:0]   code_mask;
  logic          enough;

  always_comb begin
    width = WB'(lzwvd_pkg::MIN_CODE_BITS);
    for (int s = lzwvd_pkg::MIN_CODE_BITS; s < MB; s++) begin
      if (nfc_r >= NW'(1 << s)) width = WB'(s + 1);
    end
    holder_sh = {holder_r[HW-9:0], in_data_byte};
    held_add  = held_r + HB'(8);
    enough    = held_add >= HB'(width);
    held_left = held_add - HB'(width);
    code_full = holder_sh >> held_left;
    code_mask = ((MB+1)'(1) << width) - (MB+1)'(1);
  end

  logic byte_live;
  assign byte_live = !in_command && (phase_r == lzwvd_pkg::PH_FIRST ||
                                     phase_r == lzwvd_pkg::PH_RUN);

  // code classification
  logic          is_kw;
  logic [1:0]    cls;
  always_comb begin
    is_kw = 1'b0;
    if (phase_r == lzwvd_pkg::PH_FIRST) begin
      cls = (code_r >= MB'(256)) ? lzwvd_pkg::CLS_HALT : lzwvd_pkg::CLS_FIRST;
    end else if (code_r == END_CODE) begin
      cls = lzwvd_pkg::CLS_HALT;
    end else if (code_r == RESET_CODE) begin
      cls = lzwvd_pkg::CLS_RESET;
    end else if (NW'(code_r) < nfc_r) begin
      cls = lzwvd_pkg::CLS_WALK;
    end else if (NW'(code_r) == nfc_r) begin
      cls   = lzwvd_pkg::CLS_WALK;
      is_kw = 1'b1;
    end else begin
      cls = lzwvd_pkg::CLS_HALT;
    end
  end

  // chunking
  logic [LW-1:0] n_len, rem, end_pos;
  logic [CW-1:0] cnt_calc;
  logic [7:0]    first_b;
  always_comb begin
    n_len    = (len_r > LW'(lzwvd_pkg::STRING_LIMIT)) ? LW'(lzwvd_pkg::STRING_LIMIT) : len_r;
    rem      = n_len - LW'(base_r);
    cnt_calc = (rem > LW'(lzwvd_pkg::CHUNK_BYTES)) ? CW'(lzwvd_pkg::CHUNK_BYTES) : rem[CW-1:0];
    end_pos  = len_r - LW'(1) - LW'(base_r) - LW'(idx_r);
    first_b  = kw_r ? pf_r : chain_r[7:0];
  end

  always_comb begin
    stat.have_code = byte_live && enough;
    stat.cls       = cls;
    stat.chain_big = chain_r >= MB'(256);
    stat.walk_more = (prefix_q >= MB'(256)) && (guard_r + NW'(1) < NW'(DICT));
    stat.emit_done = (idx_r == cnt_r) && !pend_r;
    stat.last      = last_r;
  end

  // dictionary, walked one entry per cycle
  logic [MB-1:0] rd_addr;
  assign rd_addr = cmd.walk ? prefix_q : chain_r;

  always_ff @(posedge clk) begin
    prefix_q <= prefix_mem[rd_addr];
    suffix_q <= suffix_mem[rd_addr];
    if (cmd.root && nfc_r < NW'(DICT)) begin
      prefix_mem[nfc_r[MB-1:0]] <= prev_r;
      suffix_mem[nfc_r[MB-1:0]] <= first_b;
    end
  end

  // string stack
  logic          st_we;
  logic [MB-1:0] st_wa;
  logic [7:0]    st_wd;
  always_comb begin
    st_we = 1'b0;
    st_wa = len_r[MB-1:0];
    st_wd = suffix_q;
    if (cmd.classify && cls == lzwvd_pkg::CLS_FIRST) begin
      st_we = 1'b1;
      st_wa = '0;
      st_wd = code_r[7:0];
    end else if (cmd.classify && cls == lzwvd_pkg::CLS_WALK && is_kw) begin
      st_we = 1'b1;
      st_wa = '0;
      st_wd = pf_r;
    end else if (cmd.walk) begin
      st_we = 1'b1;
    end else if (cmd.root) begin
      st_we = 1'b1;
      st_wd = chain_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    stack_q <= stack_mem[end_pos[MB-1:0]];
    if (st_we) stack_mem[st_wa] <= st_wd;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfc_r    <= NW'(256);
      holder_r <= '0;
      held_r   <= '0;
      prev_r   <= '0;
      pf_r     <= '0;
      phase_r  <= lzwvd_pkg::PH_FIRST;
      pend_r   <= 1'b0;
    end else begin
      if (cmd.accept && in_command) begin
        nfc_r    <= NW'(256);
        holder_r <= '0;
        held_r   <= '0;
        prev_r   <= '0;
        pf_r     <= '0;
        phase_r  <= lzwvd_pkg::PH_FIRST;
      end else if (cmd.accept && byte_live) begin
        if (enough) begin
          held_r   <= held_left;
          holder_r <= holder_sh & ((HW'(1) << held_left) - HW'(1));
        end else begin
          held_r   <= held_add;
          holder_r <= holder_sh;
        end
      end
      if (cmd.classify) begin
        unique case (cls)
          lzwvd_pkg::CLS_HALT:
            phase_r <= (phase_r == lzwvd_pkg::PH_RUN && code_r == END_CODE) ?
                       lzwvd_pkg::PH_END : lzwvd_pkg::PH_BAD;
          lzwvd_pkg::CLS_RESET: begin
            nfc_r    <= NW'(256);
            holder_r <= '0;
            held_r   <= '0;
            prev_r   <= '0;
            pf_r     <= '0;
            phase_r  <= lzwvd_pkg::PH_FIRST;
          end
          lzwvd_pkg::CLS_FIRST: begin
            prev_r  <= code_r;
            pf_r    <= code_r[7:0];
            phase_r <= lzwvd_pkg::PH_RUN;
          end
          default: ;
        endcase
      end
      if (cmd.root) begin
        if (nfc_r < NW'(DICT)) nfc_r <= nfc_r + NW'(1);
        prev_r <= code_r;
        pf_r   <= first_b;
      end
      if (cmd.chunk_start) pend_r <= 1'b0;
      else if (cmd.emit)   pend_r <= (idx_r != cnt_r);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept && byte_live && enough)
      code_r <= code_full[MB-1:0] & code_mask[MB-1:0];
    if (cmd.classify) begin
      base_r  <= '0;
      guard_r <= '0;
      kw_r    <= is_kw;
      chain_r <= is_kw ? prev_r : code_r;
      len_r   <= (cls == lzwvd_pkg::CLS_FIRST || is_kw) ? LW'(1) : LW'(0);
      if (cls == lzwvd_pkg::CLS_HALT) begin
        chunk_r  <= '0;
        cnt_r    <= '0;
        last_r   <= 1'b1;
        status_r <= (phase_r == lzwvd_pkg::PH_RUN && code_r == END_CODE) ?
                    lzwvd_pkg::ST_END : lzwvd_pkg::ST_BAD;
      end
    end
    if (cmd.walk) begin
      len_r   <= len_r + LW'(1);
      guard_r <= guard_r + NW'(1);
      chain_r <= prefix_q;
    end
    if (cmd.root) len_r <= len_r + LW'(1);
    if (cmd.chunk_start) begin
      chunk_r  <= '0;
      cnt_r    <= cnt_calc;
      idx_r    <= '0;
      status_r <= lzwvd_pkg::ST_DATA;
      last_r   <= (LW'(base_r) + LW'(cnt_calc)) >= n_len;
    end
    if (cmd.emit) begin
      if (idx_r != cnt_r) begin
        slot_r <= idx_r[lzwvd_pkg::SLOT_W-1:0];
        idx_r  <= idx_r + CW'(1);
      end
      if (pend_r) chunk_r[slot_r*8 +: 8] <= stack_q;
    end
    if (cmd.out_next) base_r <= base_r + BW'(lzwvd_pkg::CHUNK_BYTES);
  end

  assign chunk      = chunk_r;
  assign byte_count = cnt_r;
  assign last_chunk = last_r;
  assign status     = status_r;

endmodule

// ----- rtl/core/lzw_variable_width_decoder.sv -----
// a decoded code: its dictionary chain is walked (not for a first code), then its string goes out in 64-byte chunks
// throughput: one item at a time; decoding a long string is bounded by
// the one-entry-per-cycle chain walk and the one-byte-per-cycle string stack read
// reset: synchronous active low; dictionary counters, bit buffer and phase cleared, no
// clearing pass, dictionary memories hold stale data that is never read before written
module lzw_variable_width_decoder #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes_0_7,
  output logic [63:0] out_bytes_8_15,
  output logic [63:0] out_bytes_16_23,
  output logic [63:0] out_bytes_24_31,
  output logic [63:0] out_bytes_32_39,
  output logic [63:0] out_bytes_40_47,
  output logic [63:0] out_bytes_48_55,
  output logic [63:0] out_bytes_56_63,
  output logic [6:0]  out_byte_count,
  output logic        out_last_chunk,
  output logic [1:0]  out_status
);

  // command and status between sequencer and datapath
  lzwvd_pkg::dp_cmd_t  cmd;
  lzwvd_pkg::dp_stat_t stat;
  logic [lzwvd_pkg::CHUNK_W-1:0] chunk;

  // sequencer: accept, classify, walk chain, emit chunks, wait for transfer
  lzwvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: bit unpacker, dictionary memories, string stack, chunk register
  lzwvd_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .chunk        (chunk),
    .byte_count   (out_byte_count),
    .last_chunk   (out_last_chunk),
    .status       (out_status)
  );

  // byte 0 sits in the low bits of the chunk
  assign out_bytes_0_7   = chunk[63:0];
  assign out_bytes_8_15  = chunk[127:64];
  assign out_bytes_16_23 = chunk[191:128];
  assign out_bytes_24_31 = chunk[255:192];
  assign out_bytes_32_39 = chunk[319:256];
  assign out_bytes_40_47 = chunk[383:320];
  assign out_bytes_48_55 = chunk[447:384];
  assign out_bytes_56_63 = chunk[511:448];

  // no new input while a result is pending
  a_no_accept_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // halt results carry no bytes and close the string
  a_halt_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != lzwvd_pkg::ST_DATA) |-> (out_byte_count == 7'd0 && out_last_chunk))
    else $error("malformed halt result");

  // data chunks hold between one and 64 bytes
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == lzwvd_pkg::ST_DATA) |->
      (out_byte_count != 7'd0 && out_byte_count <= 7'd64))
    else $error("bad chunk byte count");

  // a non-final chunk is always a full one
  a_full_middle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_chunk) |-> (out_byte_count == 7'd64))
    else $error("short chunk before end of string");

endmodule
